FILE: hw/rtl/sspq_pkg.sv
// shared types, widths and status codes for the stable sorted priority queue
package sspq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int PRIO_W        = 8;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // one slot of the queue
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } entry_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } op_t;

endpackage

FILE: hw/rtl/stable_sorted_priority_queue.sv
// top level: chain of queue cells, occupancy counter and result register
//
// channel | direction | tdata (low bit up)              | tuser
// s_      | in        | value[31:0] prio[39:32]         | cmd[0]
// m_      | out       | status[1:0] head_valid[2]       | -
//         |           | head_value[34:3] head_prio[42:35] occupancy[47:43]
//
// one transaction per cycle while s_tready is high: every cell compares against the new
// priority at once and all cells shift by one place together.
// the result appears the cycle after the input is taken and holds while m_tready is low;
// s_tready is high whenever the result register is empty or being drained.
// reset clears the valid bit of every cell and the count, no clearing pass.
module stable_sorted_priority_queue #(
    parameter int DEPTH = sspq_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], prio[39:32]
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status, head_valid, head_value, head_prio, occupancy
);
    import sspq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    entry_t          ent  [DEPTH];
    logic            take [DEPTH];
    logic [DEPTH-1:0] valid_vec;
    op_t             op;

    logic            accept;
    logic            full;
    logic            empty;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic            m_valid_reg;
    logic [CW+OCC_W-1:0] count_ext;
    logic signed [VALUE_W-1:0] head_value;
    logic [PRIO_W-1:0] head_prio;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = ent[DEPTH-1].valid;
    assign empty    = !ent[0].valid;

    assign op.ins   = accept && (s_tuser[0] == CMD_INSERT) && !full;
    assign op.rem   = accept && (s_tuser[0] == CMD_REMOVE) && !empty;
    assign op.value = s_tdata[VALUE_W-1:0];
    assign op.prio  = s_tdata[VALUE_W+PRIO_W-1:VALUE_W];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            entry_t left_e;
            logic   left_t;
            entry_t right_e;
            if (i == 0) begin : g_first
                assign left_e = '0;
                assign left_t = 1'b0;
            end else begin : g_inner
                assign left_e = ent[i-1];
                assign left_t = take[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign right_e = '0;
            end else begin : g_body
                assign right_e = ent[i+1];
            end
            sspq_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .op          (op),
                .left_entry  (left_e),
                .left_take   (left_t),
                .right_entry (right_e),
                .entry       (ent[i]),
                .take        (take[i])
            );
            assign valid_vec[i] = ent[i].valid;
        end
    endgenerate

    always_comb begin
        count_next  = count_reg;
        status_next = ST_OK;
        if (accept) begin
            unique case (s_tuser[0])
                CMD_INSERT: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
        end
    end

    // cells and count only move on an accepted transaction, which also reloads the result
    assign count_ext  = {{OCC_W{1'b0}}, count_reg};
    assign head_value = ent[0].valid ? ent[0].value : '0;
    assign head_prio  = ent[0].valid ? ent[0].prio  : '0;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {count_ext[OCC_W-1:0], head_prio, head_value, ent[0].valid, status_reg};

`ifndef SYNTHESIS
    logic [DEPTH:0] valid_plus_one;
    assign valid_plus_one = {1'b0, valid_vec} + {{DEPTH{1'b0}}, 1'b1};

    // count always equals the number of occupied cells
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == count_reg)
        else $error("occupancy count disagrees with cell valid bits");

    // occupied cells form one run from the head
    a_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(valid_plus_one))
        else $error("gap in occupied cells");

    // a rejected insert leaves the count alone
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tuser[0] == CMD_INSERT) && full |=> count_reg == $past(count_reg))
        else $error("insert into full queue changed the count");

    // removal from an empty queue reports an empty head
    a_empty_head: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tuser[0] == CMD_REMOVE) && empty |=> m_tvalid && !m_tdata[2])
        else $error("removal from empty queue shows a head");
`endif

endmodule

FILE: hw/rtl/sspq_cell.sv
// one slot of the shift-register queue with its own priority comparator
module sspq_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  sspq_pkg::op_t    op,
    input  sspq_pkg::entry_t left_entry,
    input  logic            left_take,
    input  sspq_pkg::entry_t right_entry,
    output sspq_pkg::entry_t entry,
    output logic            take
);
    import sspq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // slot lies at or behind the insert position: empty or strictly larger number
    assign take  = !entry_reg.valid || (entry_reg.prio > op.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (op.ins) begin
            if (take) begin
                if (left_take) begin
                    entry_next = left_entry;
                end else begin
                    entry_next.valid = 1'b1;
                    entry_next.value = op.value;
                    entry_next.prio  = op.prio;
                end
            end
        end else if (op.rem) begin
            entry_next = right_entry;
        end
    end

    // only the valid bit needs a reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
        entry_reg.value <= entry_next.value;
        entry_reg.prio  <= entry_next.prio;
    end

endmodule

FILE: tb/stable_sorted_priority_queue_tb.sv
// self-checking testbench for the stable sorted priority queue
module stable_sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sspq_pkg::*;

    localparam int QDEPTH = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1125;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic                      head_valid;
        logic signed [VALUE_W-1:0] head_value;
        logic [PRIO_W-1:0]         head_prio;
        logic [OCC_W-1:0]          occupancy;
    } head_report_t;

    // shadow copy of the queue plus the reports it owes the result channel
    class queue_tracker;
        logic signed [VALUE_W-1:0] shadow_values[QDEPTH];
        logic [PRIO_W-1:0]         shadow_prios[QDEPTH];
        int                        shadow_count;
        head_report_t              reports_due[$];
        int errors, checked, inserts, removes, full_drops, empty_removes, peak;

        function int outstanding();
            return reports_due.size();
        endfunction

        function void note_request(logic cmd, logic signed [VALUE_W-1:0] value,
                                   logic [PRIO_W-1:0] prio);
            head_report_t r;
            int pos;
            r.status = ST_OK;
            if (cmd == CMD_INSERT) begin
                inserts++;
                if (shadow_count >= QDEPTH) begin
                    r.status = ST_FULL;
                    full_drops++;
                end else begin
                    // new entry goes behind everything with a priority number <= its own
                    pos = shadow_count;
                    while (pos > 0 && shadow_prios[pos-1] > prio) begin
                        shadow_values[pos] = shadow_values[pos-1];
                        shadow_prios[pos]  = shadow_prios[pos-1];
                        pos--;
                    end
                    shadow_values[pos] = value;
                    shadow_prios[pos]  = prio;
                    shadow_count++;
                end
            end else begin
                removes++;
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                    empty_removes++;
                end else begin
                    for (int i = 0; i + 1 < shadow_count; i++) begin
                        shadow_values[i] = shadow_values[i+1];
                        shadow_prios[i]  = shadow_prios[i+1];
                    end
                    shadow_count--;
                end
            end
            if (shadow_count > peak)
                peak = shadow_count;
            r.head_valid = (shadow_count > 0);
            r.head_value = (shadow_count > 0) ? shadow_values[0] : '0;
            r.head_prio  = (shadow_count > 0) ? shadow_prios[0] : '0;
            r.occupancy  = shadow_count[OCC_W-1:0];
            reports_due.push_back(r);
        endfunction

        function void check_report(logic [47:0] beat);
            head_report_t got, want;
            got.status     = beat[1:0];
            got.head_valid = beat[2];
            got.head_value = beat[34:3];
            got.head_prio  = beat[42:35];
            got.occupancy  = beat[47:43];
            if (reports_due.size() == 0) begin
                $display("%0t: result with nothing outstanding, tdata %h", $time, beat);
                errors++;
                return;
            end
            want = reports_due.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.head_valid !== want.head_valid) begin
                $display("%0t: head_valid expected %0b actual %0b", $time,
                         want.head_valid, got.head_valid);
                errors++;
            end
            if (got.head_value !== want.head_value) begin
                $display("%0t: head_value expected %h actual %h", $time,
                         want.head_value, got.head_value);
                errors++;
            end
            if (got.head_prio !== want.head_prio) begin
                $display("%0t: head_prio expected %0d actual %0d", $time,
                         want.head_prio, got.head_prio);
                errors++;
            end
            if (got.occupancy !== want.occupancy) begin
                $display("%0t: occupancy expected %0d actual %0d", $time,
                         want.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // value[31:0], prio[39:32]
    logic [0:0]  s_tuser  = '0;   // cmd[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // status, head_valid, head_value, head_prio, occupancy

    bit           no_idle = 1'b0;
    queue_tracker tracker;

    stable_sorted_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 19);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_request(s_tuser[0], s_tdata[31:0], s_tdata[39:32]);
            if (m_tvalid && m_tready)
                tracker.check_report(m_tdata);
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_item(logic cmd, logic signed [VALUE_W-1:0] value,
                             logic [PRIO_W-1:0] prio);
        if (!no_idle && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            do
                @(negedge aclk);
            while ($urandom_range(0, 99) < 19);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prio, value};
        s_tuser  <= cmd;
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (tracker.outstanding() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [PRIO_W-1:0] pick_prio(int mode);
        case (mode)
            0:       return PRIO_W'($urandom_range(0, 255));
            1:       return PRIO_W'($urandom_range(0, 3));
            2:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return PRIO_W'($urandom_range(100, 102));
        endcase
    endfunction

    initial begin
        int done, burst_len, ins_pct, prio_mode;
        tracker = new();
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: removal on empty, extremes, ties, fill past full, partial drain
        send_item(CMD_REMOVE, 32'sh1234_5678, 8'd7);
        send_item(CMD_INSERT, 32'sh8000_0000, 8'd255);
        send_item(CMD_INSERT, 32'sh7fff_ffff, 8'd0);
        send_item(CMD_INSERT, 32'shffff_ffff, 8'd0);
        send_item(CMD_INSERT, 32'sh0000_0000, 8'd128);
        for (int i = 0; i < 11; i++)
            send_item(CMD_INSERT, 32'sh1000 + i, (i % 3 == 0) ? 8'd128 : 8'd64);
        send_item(CMD_INSERT, 32'sh5555_aaaa, 8'd255);
        send_item(CMD_INSERT, 32'shaaaa_5555, 8'd0);
        for (int i = 0; i < 7; i++)
            send_item(CMD_REMOVE, $urandom, PRIO_W'($urandom_range(0, 255)));
        wait_drained();

        // random bursts with varying insert/remove mix to sweep fill and drain
        done = 0;
        while (done < RANDOM_ITEMS) begin
            burst_len = $urandom_range(8, 48);
            case ($urandom_range(0, 3))
                0:       ins_pct = 15;
                1:       ins_pct = 50;
                2:       ins_pct = 85;
                default: ins_pct = 97;
            endcase
            prio_mode = $urandom_range(0, 3);
            for (int i = 0; i < burst_len && done < RANDOM_ITEMS; i++) begin
                no_idle = (done >= 400 && done < 600);
                if (done == 700)
                    wait_drained();
                send_item(($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE,
                          $urandom, pick_prio(prio_mode));
                done++;
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        $display("covered %0d inserts (%0d dropped while full) and %0d removals (%0d on empty)",
                 tracker.inserts, tracker.full_drops, tracker.removes, tracker.empty_removes);
        $display("%0d results checked, queue reached %0d entries", tracker.checked, tracker.peak);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("stable_sorted_priority_queue_tb: clean");
        end else begin
            $display("stable_sorted_priority_queue_tb: errors");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout waiting for the queue");
        $display("stable_sorted_priority_queue_tb: errors");
        $finish;
    end

endmodule
